/* rtl/wavp_pkg.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared types, ids and codes for the RIFF/WAVE byte parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 16;
  localparam int unsigned FRAME_IDX_W     = $clog2(MAX_FRAME_BYTES);

  localparam logic [31:0] ID_RIFF     = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE     = 32'h4556_4157;
  localparam logic [31:0] ID_FMT      = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA     = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] FMT_TAG_PCM = 16'd1;
  localparam logic [15:0] BITS_8      = 16'd8;
  localparam logic [15:0] BITS_16     = 16'd16;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SUBHDR = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DATA   = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_RIFF    = 3'd0,
    ERR_BAD_WAVE    = 3'd1,
    ERR_FMT_SHORT   = 3'd2,
    ERR_NOT_PCM     = 3'd3,
    ERR_BAD_BITS    = 3'd4,
    ERR_DATA_EARLY  = 3'd5,
    ERR_NO_DATA     = 3'd6,
    ERR_BLOCK_ALIGN = 3'd7
  } err_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] sample_q15;
    logic [31:0]        sample_rate;
    err_t               error_code;
  } result_t;

endpackage

/* rtl/wavp_if.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser channels
// Valid/ready channels for input bytes and parser results.
// ----------------------------------------------------------------------------
interface wavp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input file_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface wavp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample_q15;
  logic [31:0]        sample_rate;
  logic [2:0]         error_code;

  modport source (output valid, output kind, output sample_q15, output sample_rate,
                  output error_code, input ready);
  modport sink (input valid, input kind, input sample_q15, input sample_rate,
                input error_code, output ready);
endinterface

/* rtl/wavp_core.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser core
// Parser state registers and the single-pass step logic for one byte.
// ----------------------------------------------------------------------------
module wavp_core
  import wavp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] file_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output result_t    res
);

  phase_t                 phase, phase_next, cur_phase;
  logic [31:0]            byte_counter, byte_counter_next, cur_bc;
  logic [31:0]            word_shift, word_shift_next, cur_ws;
  logic [31:0]            chunk_length, chunk_length_next, cur_cl;
  logic [31:0]            rate_store, rate_store_next, cur_rate;
  logic [15:0]            frame_bytes, frame_bytes_next, cur_fb;
  logic                   wide_samples, wide_samples_next, cur_wide;
  logic                   format_seen, format_seen_next, cur_fs;
  logic [FRAME_IDX_W-1:0] frame_index, frame_index_next, cur_fi;
  logic [7:0]             sample_low, sample_low_next, cur_sl;

  logic [31:0]          bc_inc, ws_shift, fmt_ws, data_ws;
  logic [FRAME_IDX_W:0] fi_inc;
  logic                 data_go, frame_done, chunk_end;
  logic                 fail, announce, emit;
  err_t                 fail_code;

  assign cur_phase = first_byte ? PH_HEADER : phase;
  assign cur_bc    = first_byte ? '0 : byte_counter;
  assign cur_ws    = first_byte ? '0 : word_shift;
  assign cur_cl    = first_byte ? '0 : chunk_length;
  assign cur_rate  = first_byte ? '0 : rate_store;
  assign cur_fb    = first_byte ? '0 : frame_bytes;
  assign cur_wide  = first_byte ? 1'b0 : wide_samples;
  assign cur_fs    = first_byte ? 1'b0 : format_seen;
  assign cur_fi    = first_byte ? '0 : frame_index;
  assign cur_sl    = first_byte ? '0 : sample_low;

  assign bc_inc     = cur_bc + 32'd1;
  assign ws_shift   = {file_byte, cur_ws[31:8]};
  assign fmt_ws     = (cur_bc < FMT_MIN_LEN) ? ws_shift : cur_ws;
  assign chunk_end  = (bc_inc == cur_cl);
  assign data_go    = (cur_bc < cur_cl);
  assign fi_inc     = {1'b0, cur_fi} + {{FRAME_IDX_W{1'b0}}, 1'b1};
  assign frame_done = ({{(16 - FRAME_IDX_W - 1){1'b0}}, fi_inc} >= cur_fb);

  always_comb begin
    data_ws = cur_ws;
    if (cur_fi == '0) begin
      data_ws = cur_wide ? {24'd0, file_byte} : {16'd0, file_byte ^ 8'h80, 8'd0};
    end else if (cur_fi == {{(FRAME_IDX_W-1){1'b0}}, 1'b1} && cur_wide) begin
      data_ws = {16'd0, file_byte, cur_sl};
    end
  end

  // next phase and events
  always_comb begin
    phase_next = cur_phase;
    fail       = 1'b0;
    fail_code  = ERR_BAD_RIFF;
    announce   = 1'b0;
    emit       = 1'b0;
    case (cur_phase)
      PH_HEADER: begin
        if (cur_bc == 32'd3 && ws_shift != ID_RIFF) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_RIFF;
        end else if (cur_bc == 32'd11) begin
          if (ws_shift != ID_WAVE) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_WAVE;
          end else begin
            phase_next = PH_SUBHDR;
          end
        end
      end
      PH_SUBHDR: begin
        if (cur_bc == 32'd7) begin
          if (cur_cl == ID_FMT) begin
            if (ws_shift < FMT_MIN_LEN) begin
              fail      = 1'b1;
              fail_code = ERR_FMT_SHORT;
            end else begin
              phase_next = PH_FMT;
            end
          end else if (cur_cl == ID_DATA) begin
            if (!cur_fs) begin
              fail      = 1'b1;
              fail_code = ERR_DATA_EARLY;
            end else begin
              announce   = 1'b1;
              phase_next = PH_DATA;
            end
          end else begin
            phase_next = (ws_shift == '0) ? PH_SUBHDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (cur_bc == 32'd1 && fmt_ws[31:16] != FMT_TAG_PCM) begin
          fail      = 1'b1;
          fail_code = ERR_NOT_PCM;
        end else if (cur_bc == 32'd15 && fmt_ws[31:16] != BITS_8 &&
                     fmt_ws[31:16] != BITS_16) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_BITS;
        end else if (cur_bc == 32'd15 &&
                     (cur_fb == '0 || cur_fb > 16'(MAX_FRAME_BYTES))) begin
          fail      = 1'b1;
          fail_code = ERR_BLOCK_ALIGN;
        end else if (chunk_end) begin
          phase_next = PH_SUBHDR;
        end
      end
      PH_SKIP: begin
        if (chunk_end) begin
          phase_next = PH_SUBHDR;
        end
      end
      PH_DATA: begin
        emit = data_go && frame_done;
      end
      default: begin
        phase_next = cur_phase;
      end
    endcase
    if (fail) begin
      phase_next = PH_HALT;
    end
    if (last_byte) begin
      if (!fail && !announce && !emit && phase_next != PH_DATA && phase_next != PH_HALT) begin
        fail      = 1'b1;
        fail_code = ERR_NO_DATA;
      end
      phase_next = PH_HALT;
    end
  end

  // result
  always_comb begin
    res = '0;
    res.valid = fail || announce || emit;
    if (fail) begin
      res.kind       = KIND_ERROR;
      res.error_code = fail_code;
    end else if (announce) begin
      res.kind        = KIND_FORMAT;
      res.sample_rate = cur_rate;
    end else begin
      res.kind       = KIND_SAMPLE;
      res.sample_q15 = data_ws[15:0];
    end
  end

  // datapath
  always_comb begin
    byte_counter_next = cur_bc;
    word_shift_next   = cur_ws;
    chunk_length_next = cur_cl;
    rate_store_next   = cur_rate;
    frame_bytes_next  = cur_fb;
    wide_samples_next = cur_wide;
    format_seen_next  = cur_fs;
    frame_index_next  = cur_fi;
    sample_low_next   = cur_sl;
    case (cur_phase)
      PH_HEADER: begin
        word_shift_next   = ws_shift;
        byte_counter_next = (cur_bc == 32'd11) ? '0 : bc_inc;
      end
      PH_SUBHDR: begin
        word_shift_next   = ws_shift;
        byte_counter_next = bc_inc;
        if (cur_bc == 32'd3) begin
          chunk_length_next = ws_shift;
        end else if (cur_bc == 32'd7) begin
          chunk_length_next = ws_shift;
          byte_counter_next = '0;
          frame_index_next  = '0;
        end
      end
      PH_FMT: begin
        word_shift_next   = fmt_ws;
        byte_counter_next = chunk_end ? '0 : bc_inc;
        if (cur_bc == 32'd7) begin
          rate_store_next = fmt_ws;
        end
        if (cur_bc == 32'd13) begin
          frame_bytes_next = fmt_ws[31:16];
        end
        if (cur_bc == 32'd15) begin
          wide_samples_next = (fmt_ws[31:16] == BITS_16);
          format_seen_next  = 1'b1;
        end
      end
      PH_SKIP: begin
        byte_counter_next = chunk_end ? '0 : bc_inc;
      end
      PH_DATA: begin
        if (data_go) begin
          byte_counter_next = bc_inc;
          word_shift_next   = data_ws;
          if (cur_fi == '0) begin
            sample_low_next = file_byte;
          end
          frame_index_next = frame_done ? '0 : fi_inc[FRAME_IDX_W-1:0];
        end
      end
      default: begin
        byte_counter_next = cur_bc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_counter <= '0;
      word_shift   <= '0;
      chunk_length <= '0;
      rate_store   <= '0;
      frame_bytes  <= '0;
      wide_samples <= 1'b0;
      format_seen  <= 1'b0;
      frame_index  <= '0;
      sample_low   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      word_shift   <= word_shift_next;
      chunk_length <= chunk_length_next;
      rate_store   <= rate_store_next;
      frame_bytes  <= frame_bytes_next;
      wide_samples <= wide_samples_next;
      format_seen  <= format_seen_next;
      frame_index  <= frame_index_next;
      sample_low   <= sample_low_next;
    end
  end

`ifndef SYNTHESIS
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid && res.kind == KIND_ERROR) |=> (phase == PH_HALT))
    else $error("error result did not halt the parser");

  a_last_halts: assert property (@(posedge clk) disable iff (rst)
    (fire && last_byte) |=> (phase == PH_HALT))
    else $error("last byte did not halt the parser");

  a_data_has_format: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (format_seen && {{(16 - FRAME_IDX_W){1'b0}}, frame_index} < frame_bytes))
    else $error("data phase without a valid format");

  a_announce_enters_data: assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid && res.kind == KIND_FORMAT && !last_byte) |=> (phase == PH_DATA))
    else $error("format announcement outside data start");
`endif

endmodule

/* rtl/wavp_out_stage.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser output stage
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module wavp_out_stage
  import wavp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t res,
  output logic    can_load,
  wavp_result_if.source result
);

  logic    valid;
  result_t held;

  assign can_load          = !valid || result.ready;
  assign result.valid      = valid;
  assign result.kind       = held.kind;
  assign result.sample_q15 = held.sample_q15;
  assign result.sample_rate = held.sample_rate;
  assign result.error_code = held.error_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire && res.valid) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      held <= res;
    end
  end

endmodule

/* rtl/wav_pcm_stream_parser.sv */
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Parses a RIFF/WAVE byte stream and emits rate, Q1.15 samples and errors.
//
//   channel  dir  payload
//   stream   in   file_byte, first_byte, last_byte
//   result   out  kind, sample_q15, sample_rate, error_code
//
// One byte per cycle while stream.ready is high; a byte's result is shown the cycle after its transfer.
// All parser work is one pass of logic between the state and result registers.
// stream.ready drops only while a result waits and result.ready is low.
// Synchronous reset starts the parser as if a new file began.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser
  import wavp_pkg::*;
(
  input logic clk,
  input logic rst,
  wavp_byte_if.sink     stream,
  wavp_result_if.source result
);

  logic    fire;
  logic    can_load;
  result_t res;

  assign stream.ready = can_load;
  assign fire         = stream.valid && can_load;

  wavp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .file_byte  (stream.file_byte),
    .first_byte (stream.first_byte),
    .last_byte  (stream.last_byte),
    .res        (res)
  );

  wavp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule
